### rtl/phd_pkg.sv
// shared constants, codes and types for the pair distance histogram unit
package phd_pkg;

  // default build sizes
  localparam int NUM_BINS_DEF    = 256;
  localparam int NUM_SPECIES_DEF = 4;
  localparam int SUM_WIDTH_DEF   = 48;

  // fixed field widths
  localparam int IDX_W      = 24;
  localparam int DIST_W     = 24;
  localparam int TYPE_W     = 2;
  localparam int REQ_W      = 2;
  localparam int RBIN_W     = 8;
  localparam int CONC_W     = 16;
  localparam int NBCFG_W    = 9;
  localparam int VALUE_W    = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = 2 * DIST_W;
  localparam int INC_W      = 2 * CONC_W + 1;
  localparam int K_W        = PROD_W - 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BIN_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CONC_0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CONC_1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CONC_2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CONC_3    = 3'd6;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD        = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ       = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ_CLEAR = 2'd2;

  typedef struct packed {
    logic [DIST_W-1:0]            cutoff;
    logic [DIST_W-1:0]            inv_bin_width;
    logic [NBCFG_W-1:0]           num_bins;
    logic [3:0][CONC_W-1:0]       inv_conc;
  } cfg_t;

endpackage

### rtl/phd_cfg_regs.sv
// configuration register bank with its write port
module phd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [phd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [phd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output phd_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff        <= 24'hFFFFFF;
      cfg.inv_bin_width <= 24'd65536;
      cfg.num_bins      <= 9'd256;
      cfg.inv_conc[0]   <= 16'd4096;
      cfg.inv_conc[1]   <= 16'd4096;
      cfg.inv_conc[2]   <= 16'd4096;
      cfg.inv_conc[3]   <= 16'd4096;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        phd_pkg::REG_CUTOFF:        cfg.cutoff        <= cfg_data;
        phd_pkg::REG_INV_BIN_WIDTH: cfg.inv_bin_width <= cfg_data;
        phd_pkg::REG_NUM_BINS:      cfg.num_bins      <= cfg_data[phd_pkg::NBCFG_W-1:0];
        phd_pkg::REG_INV_CONC_0:    cfg.inv_conc[0]   <= cfg_data[phd_pkg::CONC_W-1:0];
        phd_pkg::REG_INV_CONC_1:    cfg.inv_conc[1]   <= cfg_data[phd_pkg::CONC_W-1:0];
        phd_pkg::REG_INV_CONC_2:    cfg.inv_conc[2]   <= cfg_data[phd_pkg::CONC_W-1:0];
        phd_pkg::REG_INV_CONC_3:    cfg.inv_conc[3]   <= cfg_data[phd_pkg::CONC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/phd_calc.sv
// registered multipliers: bin position product and pair increment
module phd_calc (
  input  logic                          clk,
  input  logic [phd_pkg::DIST_W-1:0]    distance,
  input  logic [phd_pkg::DIST_W-1:0]    inv_bin_width,
  input  logic [phd_pkg::CONC_W-1:0]    conc_a,
  input  logic [phd_pkg::CONC_W-1:0]    conc_b,
  output logic [phd_pkg::PROD_W-1:0]    product,
  output logic [phd_pkg::INC_W-1:0]     incr
);

  logic [2*phd_pkg::CONC_W-1:0] conc_prod;

  assign conc_prod = conc_a * conc_b;

  always_ff @(posedge clk) begin
    product <= distance * inv_bin_width;
    // times two is a shift
    incr    <= {conc_prod, 1'b0};
  end

endmodule

### rtl/phd_hist_mem.sv
// histogram store: registered-read memory with a clearing sweep after reset
module phd_hist_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              rst,
  output logic              clearing,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/pair_distance_histogram_unit.sv
// top level: pair distance histogram with read-modify-write sequencer
//
//  channel   handshake            payload
//  request   start / busy         req_type center_index neighbor_index center_type
//                                 neighbor_type distance read_bin last_neighbor
//  result    done (one cycle)     counted bin_out bin_value saturated last_out
//  config    cfg_wr_en            cfg_index cfg_data
//
// each item passes through the steps accept, multiply, histogram read, update and write back;
// busy stays high through the multiply, read and update steps, so no new item enters before the last is written back
// the result appears on the cycle after the update, while the next item may be accepted
// after reset a clearing pass zeroes the store one entry per cycle, over all
// NUM_SPECIES*NUM_SPECIES*NUM_BINS entries (4096 by default), with busy high
// results are never stalled; done marks each one for exactly one cycle
module pair_distance_histogram_unit #(
  parameter int NUM_BINS    = phd_pkg::NUM_BINS_DEF,
  parameter int NUM_SPECIES = phd_pkg::NUM_SPECIES_DEF,
  parameter int SUM_WIDTH   = phd_pkg::SUM_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [phd_pkg::REQ_W-1:0]       req_type,
  input  logic [phd_pkg::IDX_W-1:0]       center_index,
  input  logic [phd_pkg::IDX_W-1:0]       neighbor_index,
  input  logic [phd_pkg::TYPE_W-1:0]      center_type,
  input  logic [phd_pkg::TYPE_W-1:0]      neighbor_type,
  input  logic [phd_pkg::DIST_W-1:0]      distance,
  input  logic [phd_pkg::RBIN_W-1:0]      read_bin,
  input  logic                            last_neighbor,
  output logic                            done,
  output logic                            counted,
  output logic [phd_pkg::RBIN_W-1:0]      bin_out,
  output logic [phd_pkg::VALUE_W-1:0]     bin_value,
  output logic                            saturated,
  output logic                            last_out,
  input  logic                            cfg_wr_en,
  input  logic [phd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH  = NUM_SPECIES * NUM_SPECIES * NUM_BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int K_W    = phd_pkg::K_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  phd_pkg::cfg_t cfg;

  logic [1:0]                    state;
  logic                          clearing;

  logic [phd_pkg::REQ_W-1:0]     req_q;
  logic [phd_pkg::IDX_W-1:0]     ci_q;
  logic [phd_pkg::IDX_W-1:0]     ni_q;
  logic [phd_pkg::TYPE_W-1:0]    ct_q;
  logic [phd_pkg::TYPE_W-1:0]    nt_q;
  logic [phd_pkg::DIST_W-1:0]    dist_q;
  logic [phd_pkg::RBIN_W-1:0]    rbin_q;
  logic                          last_q;

  logic [phd_pkg::PROD_W-1:0]    product;
  logic [phd_pkg::INC_W-1:0]     incr;

  logic                          ct_ok;
  logic                          nt_ok;
  logic                          add_ok;
  logic                          rd_ok;
  logic                          rbin_ok;
  logic                          mem_access;
  logic                          clr_req;

  logic [K_W-1:0]                k_raw;
  logic [K_W-1:0]                nb_ext;
  logic [K_W-1:0]                nb_lo;
  logic [K_W-1:0]                nb;
  logic [K_W-1:0]                k_lim;
  logic [K_W-1:0]                k_cl;
  logic [BIN_W-1:0]              bin_idx;
  logic [ADDR_W-1:0]             pair_idx;
  logic [ADDR_W-1:0]             addr;
  logic [ADDR_W-1:0]             addr_q;
  logic [phd_pkg::RBIN_W-1:0]    bin_q;

  logic [SUM_WIDTH-1:0]          rd_data;
  logic [SUM_WIDTH:0]            sum;
  logic [SUM_WIDTH-1:0]          new_val;
  logic [SUM_WIDTH-1:0]          val;
  logic                          wr_en;
  logic [SUM_WIDTH-1:0]          wr_data;

  logic                          accept;

  assign busy   = clearing || (state != ST_IDLE);
  assign accept = start && !busy;

  phd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phd_calc u_calc (
    .clk           (clk),
    .distance      (dist_q),
    .inv_bin_width (cfg.inv_bin_width),
    .conc_a        (cfg.inv_conc[ct_q]),
    .conc_b        (cfg.inv_conc[nt_q]),
    .product       (product),
    .incr          (incr)
  );

  phd_hist_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SUM_WIDTH)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .rd_en    ((state == ST_ADDR) && mem_access),
    .rd_addr  (addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (addr_q),
    .wr_data  (wr_data)
  );

  // item filters
  always_comb begin
    ct_ok   = 4'(ct_q) < 4'(NUM_SPECIES);
    nt_ok   = 4'(nt_q) < 4'(NUM_SPECIES);
    add_ok  = (req_q == phd_pkg::REQ_ADD) && (ni_q > ci_q) && (dist_q < cfg.cutoff) &&
              (nt_q >= ct_q) && ct_ok && nt_ok;
    rd_ok   = ((req_q == phd_pkg::REQ_READ) || (req_q == phd_pkg::REQ_READ_CLEAR)) &&
              ct_ok && nt_ok;
    rbin_ok = 32'(rbin_q) < 32'(NUM_BINS);
    clr_req = rd_ok && rbin_ok && (req_q == phd_pkg::REQ_READ_CLEAR);
    mem_access = add_ok || (rd_ok && rbin_ok);
  end

  // bin selection and entry address
  always_comb begin
    k_raw    = product[phd_pkg::PROD_W-1:32];
    nb_ext   = K_W'(cfg.num_bins);
    nb_lo    = (nb_ext == '0) ? K_W'(1) : nb_ext;
    nb       = (nb_lo > K_W'(NUM_BINS)) ? K_W'(NUM_BINS) : nb_lo;
    k_lim    = nb - K_W'(1);
    k_cl     = (k_raw > k_lim) ? k_lim : k_raw;
    bin_idx  = add_ok ? k_cl[BIN_W-1:0] : BIN_W'(rbin_q);
    pair_idx = ADDR_W'(ct_q) * ADDR_W'(NUM_SPECIES) + ADDR_W'(nt_q);
    addr     = pair_idx * ADDR_W'(NUM_BINS) + ADDR_W'(bin_idx);
  end

  // saturating accumulate and write-back select
  always_comb begin
    sum     = {1'b0, rd_data} + (SUM_WIDTH+1)'(incr);
    new_val = sum[SUM_WIDTH] ? '1 : sum[SUM_WIDTH-1:0];
    if (add_ok) begin
      val = new_val;
    end else if (rd_ok && rbin_ok) begin
      val = rd_data;
    end else begin
      val = '0;
    end
    wr_en   = (state == ST_UPD) && (add_ok || clr_req);
    wr_data = add_ok ? new_val : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: state <= ST_ADDR;
        ST_ADDR: state <= ST_UPD;
        ST_UPD: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_type;
      ci_q   <= center_index;
      ni_q   <= neighbor_index;
      ct_q   <= center_type;
      nt_q   <= neighbor_type;
      dist_q <= distance;
      rbin_q <= read_bin;
      last_q <= last_neighbor;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ADDR) begin
      addr_q <= addr;
      bin_q  <= add_ok ? k_cl[phd_pkg::RBIN_W-1:0] : (rd_ok ? rbin_q : '0);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      counted   <= add_ok;
      bin_out   <= bin_q;
      bin_value <= phd_pkg::VALUE_W'(val);
      saturated <= mem_access && (val == '1);
      last_out  <= last_q;
    end
  end

endmodule
